FILE: rtl/i2cbm_pkg.sv
// Shared types and constants for the bit-level I2C master.
// No dependencies.
package i2cbm_pkg;

    localparam int TDATA_W = 16;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SEND  = 3'd3;
    localparam logic [2:0] CMD_WACK  = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    localparam logic [1:0] REG_START_STOP_HOLD = 2'd0;
    localparam logic [1:0] REG_WRITE_PHASE     = 2'd1;
    localparam logic [1:0] REG_READ_HALF       = 2'd2;
    localparam logic [1:0] REG_ACK_TIMEOUT     = 2'd3;

    typedef struct packed {
        logic [7:0] ack_timeout;
        logic [7:0] read_half;
        logic [7:0] write_phase;
        logic [7:0] start_stop_hold;
    } cfg_t;

    // packed from the last field down, so command sits in the low bits
    typedef struct packed {
        logic       sda_in;
        logic       send_ack;
        logic [7:0] tx_byte;
        logic [2:0] command;
    } in_item_t;

    typedef struct packed {
        logic       ack_failed;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_out;
        logic       scl;
    } out_item_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

endpackage

FILE: rtl/i2cbm_cfg.sv
// Configuration register file: timing lengths and ack timeout.
// Depends on i2cbm_pkg.
module i2cbm_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [7:0]         wr_data,
    output i2cbm_pkg::cfg_t    cfg
);
    import i2cbm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_stop_hold <= 8'd4;
            cfg_reg.write_phase     <= 8'd5;
            cfg_reg.read_half       <= 8'd2;
            cfg_reg.ack_timeout     <= 8'd250;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_START_STOP_HOLD: cfg_reg.start_stop_hold <= wr_data;
                REG_WRITE_PHASE:     cfg_reg.write_phase     <= wr_data;
                REG_READ_HALF:       cfg_reg.read_half       <= wr_data;
                REG_ACK_TIMEOUT:     cfg_reg.ack_timeout     <= wr_data;
                default:             cfg_reg.ack_timeout     <= cfg_reg.ack_timeout;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/i2cbm_fsm.sv
// Bus sequencer: advances one timebase tick per step and gives the line levels.
// Depends on i2cbm_pkg.
module i2cbm_fsm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  i2cbm_pkg::in_item_t   item,
    input  i2cbm_pkg::cfg_t       cfg,
    output i2cbm_pkg::out_item_t  result
);
    import i2cbm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_P3, PH_W1, PH_W2,
        PH_W3, PH_A1, PH_A2, PH_A3, PH_R1, PH_R2, PH_K1, PH_K2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_reg, poll_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       dir_reg, dir_next;
    logic [7:0] rx_reg, rx_next;
    logic       nack_reg, nack_next;
    logic       ackc_reg, ackc_next;
    logic       done;
    logic [7:0] len;
    logic [8:0] tick_inc;
    logic       hit;
    logic [3:0] bit_inc;

    always_comb
    begin
        case (phase_reg)
            PH_S1, PH_S2, PH_P1, PH_P3: len = cfg.start_stop_hold;
            PH_W1, PH_W2, PH_W3:        len = cfg.write_phase;
            default:                    len = cfg.read_half;
        endcase
    end

    assign tick_inc = {1'b0, tick_reg} + 9'd1;
    assign hit      = tick_inc >= {1'b0, len};
    assign bit_inc  = bit_reg + 4'd1;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        dir_next   = dir_reg;
        rx_next    = rx_reg;
        nack_next  = nack_reg;
        ackc_next  = ackc_reg;
        done       = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                case (item.command)
                    CMD_START:
                    begin
                        dir_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                        phase_next = PH_S1; tick_next = 8'd0;
                    end
                    CMD_STOP:
                    begin
                        dir_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                        phase_next = PH_P1; tick_next = 8'd0;
                    end
                    CMD_SEND:
                    begin
                        dir_next = 1'b1; scl_next = 1'b0;
                        shift_next = item.tx_byte; bit_next = 4'd0;
                        sda_next = item.tx_byte[7];
                        phase_next = PH_W1; tick_next = 8'd0;
                    end
                    CMD_WACK:
                    begin
                        nack_next = 1'b0; dir_next = 1'b0; sda_next = 1'b1;
                        phase_next = PH_A1; tick_next = 8'd0;
                    end
                    CMD_READ:
                    begin
                        dir_next = 1'b0; sda_next = 1'b1; scl_next = 1'b0;
                        bit_next = 4'd0; shift_next = 8'd0; ackc_next = item.send_ack;
                        phase_next = PH_R1; tick_next = 8'd0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            PH_S1, PH_S2, PH_P1, PH_P3, PH_W1, PH_W2, PH_W3,
            PH_A1, PH_A2, PH_R1, PH_R2, PH_K1, PH_K2:
            begin
                tick_next = hit ? 8'd0 : tick_inc[7:0];
                if (hit)
                begin
                    case (phase_reg)
                        PH_S1: begin sda_next = 1'b0; phase_next = PH_S2; end
                        PH_S2: begin scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1; end
                        PH_P1: begin scl_next = 1'b1; phase_next = PH_P2; end
                        PH_P3: begin phase_next = PH_IDLE; done = 1'b1; end
                        PH_W1: begin scl_next = 1'b1; phase_next = PH_W2; end
                        PH_W2: begin scl_next = 1'b0; phase_next = PH_W3; end
                        PH_W3:
                        begin
                            bit_next   = bit_inc;
                            shift_next = {shift_reg[6:0], 1'b0};
                            if (bit_inc >= 4'd8)
                            begin
                                phase_next = PH_IDLE; done = 1'b1;
                            end
                            else
                            begin
                                sda_next = shift_reg[6];
                                phase_next = PH_W1;
                            end
                        end
                        PH_A1: begin scl_next = 1'b1; phase_next = PH_A2; end
                        PH_A2: begin poll_next = 8'd0; phase_next = PH_A3; end
                        PH_R1:
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], item.sda_in};
                            phase_next = PH_R2;
                        end
                        PH_R2:
                        begin
                            bit_next = bit_inc;
                            scl_next = 1'b0;
                            if (bit_inc >= 4'd8)
                            begin
                                rx_next  = shift_reg;
                                dir_next = 1'b1;
                                sda_next = ~ackc_reg;
                                phase_next = PH_K1;
                            end
                            else
                            begin
                                phase_next = PH_R1;
                            end
                        end
                        PH_K1: begin scl_next = 1'b1; phase_next = PH_K2; end
                        PH_K2: begin scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1; end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
            PH_P2:
            begin
                sda_next = 1'b1; phase_next = PH_P3; tick_next = 8'd0;
            end
            PH_A3:
            begin
                if (!item.sda_in)
                begin
                    scl_next = 1'b0; phase_next = PH_IDLE; tick_next = 8'd0; done = 1'b1;
                end
                else if (poll_reg >= cfg.ack_timeout)
                begin
                    nack_next = 1'b1;
                    dir_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                    phase_next = PH_P1; tick_next = 8'd0;
                end
                else
                begin
                    poll_next = poll_reg + 8'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE; tick_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 8'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            poll_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            dir_reg   <= 1'b1;
            rx_reg    <= 8'd0;
            nack_reg  <= 1'b0;
            ackc_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            dir_reg   <= dir_next;
            rx_reg    <= rx_next;
            nack_reg  <= nack_next;
            ackc_reg  <= ackc_next;
        end
    end

    always_comb
    begin
        result.scl        = scl_next;
        result.sda_out    = sda_next;
        result.sda_drive  = dir_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.rx_byte    = rx_next;
        result.ack_failed = nack_next;
    end

endmodule

FILE: rtl/i2c_bit_level_master_unit.sv
// Bit-level I2C master top: stream ports, input and result registers.
// Depends on i2cbm_pkg, i2cbm_cfg, i2cbm_fsm.
// Path: an input transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle while m_axis_tready is high; the sequencer advances one tick per item.
// Reset (rst_n low, async): lines idle high and driven, sequencer idle, registers
// at their defaults, both pipeline stages empty.
module i2c_bit_level_master_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // command[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero pad
    input  logic [i2cbm_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
    // rx_byte[12:5], ack_failed[13], zero pad
    output logic [i2cbm_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [7:0]                   cfg_data
);
    import i2cbm_pkg::*;

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      advance;
    cfg_t      cfg;
    out_item_t result;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;

    i2cbm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    i2cbm_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_reg <= s_axis_tdata[IN_W-1:0];
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-OUT_W){1'b0}}, out_reg};

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.done_res) |-> !result.busy_res)
        else $error("command completed but sequencer still busy");

    a_fail_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.ack_failed && !out_reg.ack_failed && out_valid_reg)
        |-> (!result.scl && !result.sda_out && result.sda_drive && !result.done_res))
        else $error("ack timeout did not begin a stop condition");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
